@@ hdl/amet_pkg.sv @@
// Package with shared types and constants for the master election table.
`default_nettype none
package amet_pkg;

  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_TOUCH   = 2'd1;
  localparam logic [1:0] CMD_EXPIRE  = 2'd2;

  localparam logic [2:0] REG_SELF_ADDRESS = 3'd0;
  localparam logic [2:0] REG_SELF_METRIC  = 3'd1;
  localparam logic [2:0] REG_SELF_COUNTER = 3'd2;
  localparam logic [2:0] REG_PEER_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MAX_HEIGHT   = 3'd4;

  // One table entry.
  typedef struct packed {
    logic [47:0] address;
    logic [47:0] master;
    logic [47:0] sync_addr;
    logic [63:0] last_seen;
    logic [7:0]  distance;
    logic [31:0] metric;
    logic [31:0] counter;
  } entry_t;

  // Elected state.
  typedef struct packed {
    logic [47:0] master;
    logic [47:0] sync_addr;
    logic [7:0]  distance;
    logic [31:0] metric;
    logic [31:0] counter;
  } elect_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item
    logic scan_clear;  // clear the scan pointer and compaction write pointer
    logic compact;     // one compaction step at the scan pointer
    logic compact_end; // commit compacted count
    logic find;        // one search step
    logic find_sync;   // the search looks for the own sync master
    logic write;       // insert or update the observed peer
    logic touch;       // refresh timestamp of the found entry
    logic elect_init;  // start an election with self as candidate
    logic elect_step;  // compare one entry against the candidate
    logic elect_done;  // commit the elected state
    logic first_elect; // the commit is the first election of this item
    logic respond;     // build the result
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;   // the scan pointer reached the count
    logic found;       // the search hit
    logic valid_obs;   // the observe item passes its checks
    logic room;        // the table has a free slot
  } dp_sts_t;

endpackage
`default_nettype wire

@@ hdl/amet_ctrl.sv @@
// Controller state machine of the master election table.
`default_nettype none
module amet_ctrl
  import amet_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [1:0] cmd,
  input  wire logic       out_free,
  input  var  dp_sts_t    sts,
  output var  dp_cmd_t    cmd_o,
  output logic            busy
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DECODE  = 13'b0000000000010,
    S_COMPACT = 13'b0000000000100,
    S_E1INIT  = 13'b0000000001000,
    S_E1STEP  = 13'b0000000010000,
    S_FCLR    = 13'b0000000100000,
    S_FIND    = 13'b0000001000000,
    S_WRITE   = 13'b0000010000000,
    S_E2INIT  = 13'b0000100000000,
    S_E2STEP  = 13'b0001000000000,
    S_SICLR   = 13'b0010000000000,
    S_SIFIND  = 13'b0100000000000,
    S_RESP    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_OBSERVE;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.load = 1'b1;
          cmd_nxt    = cmd;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.scan_clear = 1'b1;
        if ((cmd_r == CMD_OBSERVE && sts.valid_obs) || cmd_r == CMD_EXPIRE)
          state_nxt = S_COMPACT;
        else if (cmd_r == CMD_TOUCH)
          state_nxt = S_FIND;
        else
          state_nxt = S_SICLR;
      end
      S_COMPACT: begin
        if (sts.scan_done) begin
          cmd_o.compact_end = 1'b1;
          state_nxt = S_E1INIT;
        end else begin
          cmd_o.compact = 1'b1;
        end
      end
      S_E1INIT: begin
        cmd_o.elect_init = 1'b1;
        state_nxt = S_E1STEP;
      end
      S_E1STEP: begin
        if (sts.scan_done) begin
          cmd_o.elect_done  = 1'b1;
          cmd_o.first_elect = 1'b1;
          state_nxt = (cmd_r == CMD_OBSERVE) ? S_FCLR : S_SICLR;
        end else begin
          cmd_o.elect_step = 1'b1;
        end
      end
      S_FCLR: begin
        cmd_o.scan_clear = 1'b1;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        if (sts.found || sts.scan_done) begin
          if (cmd_r == CMD_TOUCH) begin
            cmd_o.touch = 1'b1;
            state_nxt = S_SICLR;
          end else if (sts.found || sts.room) begin
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SICLR;
          end
        end else begin
          cmd_o.find = 1'b1;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_nxt = S_E2INIT;
      end
      S_E2INIT: begin
        cmd_o.elect_init = 1'b1;
        state_nxt = S_E2STEP;
      end
      S_E2STEP: begin
        if (sts.scan_done) begin
          cmd_o.elect_done = 1'b1;
          state_nxt = S_SICLR;
        end else begin
          cmd_o.elect_step = 1'b1;
        end
      end
      S_SICLR: begin
        cmd_o.scan_clear = 1'b1;
        state_nxt = S_SIFIND;
      end
      S_SIFIND: begin
        if (sts.found || sts.scan_done) begin
          state_nxt = S_RESP;
        end else begin
          cmd_o.find      = 1'b1;
          cmd_o.find_sync = 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.respond = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/amet_dp.sv @@
// Datapath of the master election table: peer table, election and result.
`default_nettype none
module amet_dp
  import amet_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  var  dp_cmd_t      cmd_i,
  output var  dp_sts_t      sts,
  input  wire logic [1:0]   in_cmd,
  input  wire logic [47:0]  in_addr,
  input  wire logic [47:0]  in_master,
  input  wire logic [47:0]  in_sync,
  input  wire logic [7:0]   in_dist,
  input  wire logic [31:0]  in_metric,
  input  wire logic [31:0]  in_counter,
  input  wire logic [63:0]  in_now,
  input  wire logic [47:0]  self_address,
  input  wire logic [31:0]  stn_metric,
  input  wire logic [31:0]  stn_counter,
  input  wire logic [63:0]  peer_timeout,
  input  wire logic [7:0]   max_height,
  output logic              res_accepted,
  output logic              res_changed,
  output logic [4:0]        res_expired,
  output var  elect_t       res_state,
  output logic              res_sync_is_peer
);

  localparam int IW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);

  entry_t          tbl_r [MAX_PEERS];
  logic [CW-1:0]   count_r, scan_r, wptr_r, hit_r;
  logic            found_r, accepted_r, changed_r, sel_self_r;
  logic [1:0]      cmd_r;
  logic [47:0]     addr_r, master_r, sync_r;
  logic [7:0]      dist_r;
  logic [31:0]     metric_r, counter_r;
  logic [63:0]     now_r;
  elect_t          own_r, cand_r;
  logic [4:0]      expired_r;

  logic [IW-1:0] scan_ix, wptr_ix, hit_ix, count_ix;
  entry_t        cur;
  logic          fresh, eligible, beats, hit;
  logic [63:0]   age;
  logic [47:0]   key;
  elect_t        elect_nxt;

  assign scan_ix  = scan_r[IW-1:0];
  assign wptr_ix  = wptr_r[IW-1:0];
  assign hit_ix   = hit_r[IW-1:0];
  assign count_ix = count_r[IW-1:0];
  assign cur      = tbl_r[scan_ix];

  assign age   = now_r - cur.last_seen;
  assign fresh = (cur.last_seen > now_r) || (age <= peer_timeout);
  assign eligible = (cur.distance < max_height) && (cur.sync_addr != self_address);

  // Candidate ordering: counter, metric, smaller distance, larger address.
  always_comb begin
    if (cur.counter != cand_r.counter)
      beats = cur.counter > cand_r.counter;
    else if (cur.metric != cand_r.metric)
      beats = cur.metric > cand_r.metric;
    else if (cur.distance != cand_r.distance)
      beats = cur.distance < cand_r.distance;
    else
      beats = cur.address > cand_r.sync_addr;
  end

  // In the sync-is-peer search the key is own sync master; otherwise the item address.
  assign key = cmd_i.find_sync ? own_r.sync_addr : addr_r;
  assign hit = (cur.address == key);

  always_comb begin
    if (sel_self_r) begin
      elect_nxt.master    = self_address;
      elect_nxt.sync_addr = self_address;
      elect_nxt.distance  = 8'd0;
      elect_nxt.metric    = stn_metric;
      elect_nxt.counter   = stn_counter;
    end else begin
      elect_nxt = cand_r;
      elect_nxt.distance = cand_r.distance + 8'd1;
    end
  end

  assign sts.scan_done = (scan_r >= count_r);
  assign sts.found     = found_r;
  assign sts.valid_obs = (addr_r != '0) && (master_r != '0) && (sync_r != '0) &&
                         (addr_r != self_address);
  assign sts.room      = (count_r < CW'(MAX_PEERS));

  // Table storage: entries are registers, written at one computed index per cycle.
  always_ff @(posedge clk) begin
    if (cmd_i.compact && fresh && (wptr_r != scan_r))
      tbl_r[wptr_ix] <= cur;
    if (cmd_i.write) begin
      if (found_r) begin
        tbl_r[hit_ix].master    <= master_r;
        tbl_r[hit_ix].sync_addr <= sync_r;
        tbl_r[hit_ix].last_seen <= now_r;
        tbl_r[hit_ix].distance  <= dist_r;
        tbl_r[hit_ix].metric    <= metric_r;
        tbl_r[hit_ix].counter   <= counter_r;
      end else begin
        tbl_r[count_ix] <= '{address: addr_r, master: master_r, sync_addr: sync_r,
                              last_seen: now_r, distance: dist_r, metric: metric_r,
                              counter: counter_r};
      end
    end
    if (cmd_i.touch && found_r)
      tbl_r[hit_ix].last_seen <= now_r;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r     <= in_cmd;
      addr_r    <= in_addr;
      master_r  <= in_master;
      sync_r    <= in_sync;
      dist_r    <= in_dist;
      metric_r  <= in_metric;
      counter_r <= in_counter;
      now_r     <= in_now;
    end
    if (cmd_i.elect_init) begin
      sel_self_r          <= 1'b1;
      cand_r.master       <= self_address;
      cand_r.sync_addr    <= self_address;
      cand_r.distance     <= 8'd0;
      cand_r.metric       <= stn_metric;
      cand_r.counter      <= stn_counter;
    end else if (cmd_i.elect_step && eligible && beats) begin
      sel_self_r          <= 1'b0;
      cand_r.master       <= cur.master;
      cand_r.sync_addr    <= cur.address;
      cand_r.distance     <= cur.distance;
      cand_r.metric       <= cur.metric;
      cand_r.counter      <= cur.counter;
    end
    if (cmd_i.find && hit)
      hit_r <= scan_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      scan_r     <= '0;
      wptr_r     <= '0;
      found_r    <= 1'b0;
      accepted_r <= 1'b0;
      changed_r  <= 1'b0;
      expired_r  <= '0;
      own_r      <= '{master: '0, sync_addr: '0, distance: '0,
                      metric: 32'd60, counter: '0};
      res_accepted     <= 1'b0;
      res_changed      <= 1'b0;
      res_expired      <= '0;
      res_state        <= '0;
      res_sync_is_peer <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        accepted_r <= 1'b0;
        changed_r  <= 1'b0;
        expired_r  <= '0;
      end
      if (cmd_i.scan_clear) begin
        scan_r  <= '0;
        wptr_r  <= '0;
        found_r <= 1'b0;
      end
      if (cmd_i.compact) begin
        scan_r <= scan_r + CW'(1);
        if (fresh)
          wptr_r <= wptr_r + CW'(1);
      end
      if (cmd_i.compact_end) begin
        expired_r <= 5'(count_r - wptr_r);
        count_r   <= wptr_r;
        scan_r    <= '0;
      end
      if (cmd_i.elect_init)
        scan_r <= '0;
      if (cmd_i.elect_step)
        scan_r <= scan_r + CW'(1);
      if (cmd_i.elect_done) begin
        own_r <= elect_nxt;
        if (elect_nxt != own_r)
          changed_r <= 1'b1;
        if (cmd_r == CMD_EXPIRE)
          accepted_r <= 1'b1;
      end
      if (cmd_i.find) begin
        if (hit)
          found_r <= 1'b1;
        else
          scan_r <= scan_r + CW'(1);
      end
      if (cmd_i.write) begin
        accepted_r <= 1'b1;
        if (!found_r)
          count_r <= count_r + CW'(1);
      end
      if (cmd_i.touch && found_r)
        accepted_r <= 1'b1;
      if (cmd_i.respond) begin
        res_accepted     <= accepted_r;
        res_changed      <= changed_r;
        res_expired      <= expired_r;
        res_state        <= own_r;
        res_sync_is_peer <= found_r && (own_r.sync_addr != self_address);
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/awdl_master_election_table.sv @@
// Top level of the master election table: channels, configuration and checks.
//
// Usage. Items arrive on the in_ stream: tuser carries the command, tdata the
// peer fields and the current time. One result leaves on the out_ stream for
// every item, with tdata holding the acceptance flags, the expired count and
// the elected state. The user writes configuration registers via the cfg_
// channel only while idle (unenforced); writes never re-elect by themselves.
//
// Timing. One item at a time runs through a controller that walks the table
// one entry a cycle: compaction, election, search, re-election and a final
// search for the sync master, each run as the command needs it, and the
// next item can be taken in the cycle after the result is produced.
// in_tready is high only while no item is in work.
//
// Reset clears the peer count and output register, resets the elected state.
// The result register holds its transfer while out_tready is low; the next
// item is taken once the result is moved into it, so a stalled receiver
// holds at most one result waiting plus one item in work.
`default_nettype none
module awdl_master_election_table
  import amet_pkg::*;
#(
  parameter int MAX_PEERS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: peer_address, peer_master, peer_sync_master, peer_distance,
  // peer_master_metric, peer_master_counter, now_time (from bit 0 up)
  input  wire logic [279:0] in_tdata,
  // tuser: cmd
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: accepted, changed, expired_count, elected_master,
  // elected_sync_master, elected_distance, elected_metric, elected_counter,
  // sync_is_peer (from bit 0 up)
  output logic [175:0]      out_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  logic [47:0] self_address_r;
  logic [31:0] stn_metric_r, stn_counter_r;
  logic [63:0] peer_timeout_r;
  logic [7:0]  max_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_address_r <= '0;
      stn_metric_r   <= 32'd60;
      stn_counter_r  <= '0;
      peer_timeout_r <= 64'd2000000;
      max_height_r   <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SELF_ADDRESS: self_address_r <= cfg_data[47:0];
        REG_SELF_METRIC:  stn_metric_r   <= cfg_data[31:0];
        REG_SELF_COUNTER: stn_counter_r  <= cfg_data[31:0];
        REG_PEER_TIMEOUT: peer_timeout_r <= cfg_data;
        REG_MAX_HEIGHT:   max_height_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t dcmd;
  dp_sts_t dsts;
  logic    busy, in_fire, out_free, out_valid_r;
  logic    r_acc, r_chg, r_sip;
  logic [4:0] r_exp;
  elect_t  r_state;

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  amet_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .cmd(in_tuser),
    .out_free(out_free), .sts(dsts), .cmd_o(dcmd), .busy(busy)
  );

  amet_dp #(.MAX_PEERS(MAX_PEERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd_i(dcmd), .sts(dsts),
    .in_cmd(in_tuser),
    .in_addr(in_tdata[47:0]), .in_master(in_tdata[95:48]),
    .in_sync(in_tdata[143:96]), .in_dist(in_tdata[151:144]),
    .in_metric(in_tdata[183:152]), .in_counter(in_tdata[215:184]),
    .in_now(in_tdata[279:216]),
    .self_address(self_address_r), .stn_metric(stn_metric_r),
    .stn_counter(stn_counter_r), .peer_timeout(peer_timeout_r),
    .max_height(max_height_r),
    .res_accepted(r_acc), .res_changed(r_chg), .res_expired(r_exp),
    .res_state(r_state), .res_sync_is_peer(r_sip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (dcmd.respond)
      out_valid_r <= 1'b1;
    else if (out_tready)
      out_valid_r <= 1'b0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {r_sip, r_state.counter, r_state.metric, r_state.distance,
                       r_state.sync_addr, r_state.master, r_exp, r_chg, r_acc};

  // An item is only taken while nothing is in work.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("item taken while busy");

  // A result is only produced when the output register is free.
  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    dcmd.respond |-> (!out_valid_r || out_tready)) else $error("result overrun");

  // Each accepted item starts work in the next cycle.
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy) else $error("item lost");

endmodule
`default_nettype wire
